### src/pid_pkg.sv
// Package for the pooled index dictionary coder: beat structs and default sizes.
// Used by every module under src/.
package pid_pkg;

  localparam int DICT_DEPTH_DEF = 64;
  localparam int ID_WIDTH_DEF   = 16;

  typedef struct packed {
    logic [15:0] global_id;
    logic        record_start;
  } item_beat_t;

  typedef struct packed {
    logic [6:0] code_bits;
    logic [2:0] code_length;
    logic       is_new;
    logic [5:0] slot;
    logic       overflow;
  } code_beat_t;

endpackage

### src/pid_cell.sv
// One dictionary slot: holds an identifier and compares it with the search key.
// Depends on pid_pkg.
module pid_cell #(
  parameter int ID_WIDTH = pid_pkg::ID_WIDTH_DEF,
  parameter int INDEX    = 0,
  parameter int CNT_W    = 7
) (
  input  logic                clk,
  input  logic [ID_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]    count,
  input  logic                write,
  output logic                match
);
  import pid_pkg::*;

  logic [ID_WIDTH-1:0] id;

  // only slots below the fill count take part in the search
  always_ff @(posedge clk) begin
    if (write && (count == CNT_W'(INDEX))) begin
      id <= key;
    end
    match <= (count > CNT_W'(INDEX)) && (id == key);
  end

endmodule

### src/pid_first_match.sv
// Lowest-slot selection over the cell match vector.
// Depends on pid_pkg.
module pid_first_match #(
  parameter int DICT_DEPTH = pid_pkg::DICT_DEPTH_DEF,
  parameter int IDX_W      = 6
) (
  input  logic [DICT_DEPTH-1:0] match,
  output logic                  hit,
  output logic [IDX_W-1:0]      index
);
  import pid_pkg::*;

  logic [DICT_DEPTH-1:0] lowest;

  // isolate the lowest set bit, then encode the one-hot result
  assign lowest = match & (~match + DICT_DEPTH'(1));
  assign hit    = |match;

  always_comb begin
    index = '0;
    for (int i = 0; i < DICT_DEPTH; i++) begin
      if (lowest[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

### src/pooled_index_dictionary_coder.sv
// Top level of the pooled index dictionary coder: control, fill count, output register.
// Depends on pid_pkg, pid_cell, pid_first_match.
//
//  channel | direction | handshake             | payload
//  item    | in        | item_valid/item_stall | item (item_beat_t)
//  code    | out       | code_valid/code_stall | code (code_beat_t)
//
// Each item passes a compare state, in which every cell compares its slot with the key,
// then a resolve state, in which the lowest match is picked, the result is loaded and
// a miss is appended. The next item is taken in the resolve state, so items overlap.
// A stalled result holds the resolve state until the output register frees.
// rst clears the fill count and the control state; slot contents are left as they are.
module pooled_index_dictionary_coder #(
  parameter int DICT_DEPTH = pid_pkg::DICT_DEPTH_DEF,
  parameter int ID_WIDTH   = pid_pkg::ID_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  pid_pkg::item_beat_t item,
  output logic               code_valid,
  input  logic               code_stall,
  output pid_pkg::code_beat_t code
);
  import pid_pkg::*;

  localparam int IDX_W = $clog2(DICT_DEPTH);
  localparam int CNT_W = $clog2(DICT_DEPTH + 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  // ceil(log2(n)) for a fill count
  function automatic logic [4:0] index_bits(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] v;
    logic [4:0]       b;
    v = n - CNT_W'(1);
    b = '0;
    if (n != '0) begin
      for (int i = 0; i < CNT_W; i++) begin
        if (v[i]) begin
          b = 5'(i + 1);
        end
      end
    end
    return b;
  endfunction

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [ID_WIDTH-1:0]   key;
  logic [2:0]            hit_len;
  logic [DICT_DEPTH-1:0] match;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic                  full;
  logic                  append;
  logic                  fire;
  logic                  accept;
  logic [31:0]           idx_wide;
  logic [31:0]           cnt_wide;
  logic [31:0]           key_wide;
  code_beat_t            result;

  assign fire       = (state == ST_RESOLVE) && (!code_valid || !code_stall);
  assign item_stall = !((state == ST_IDLE) || fire);
  assign accept     = item_valid && !item_stall;
  assign full       = (count == CNT_W'(DICT_DEPTH));
  assign append     = !hit && !full;
  assign key_wide   = 32'(item.global_id);

  for (genvar g = 0; g < DICT_DEPTH; g++) begin : g_cell
    pid_cell #(
      .ID_WIDTH (ID_WIDTH),
      .INDEX    (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk   (clk),
      .key   (key),
      .count (count),
      .write (fire && append),
      .match (match[g])
    );
  end

  pid_first_match #(
    .DICT_DEPTH (DICT_DEPTH),
    .IDX_W      (IDX_W)
  ) u_first (
    .match (match),
    .hit   (hit),
    .index (hit_idx)
  );

  assign idx_wide = 32'(hit_idx);
  assign cnt_wide = 32'(count);

  always_comb begin
    result = '0;
    priority if (hit) begin
      result.code_bits   = idx_wide[6:0];
      result.code_length = hit_len;
      result.slot        = idx_wide[5:0];
    end else if (full) begin
      result.code_bits   = 7'd1;
      result.code_length = 3'd1;
      result.overflow    = 1'b1;
    end else begin
      // the very first entry of a record costs no bit
      result.code_bits   = (count != '0) ? 7'd1 : 7'd0;
      result.code_length = (count != '0) ? 3'd1 : 3'd0;
      result.is_new      = 1'b1;
      result.slot        = cnt_wide[5:0];
    end
  end

  always_comb begin
    state_next = state;
    priority if (accept) begin
      state_next = ST_SEARCH;
    end else if (fire) begin
      state_next = ST_IDLE;
    end else if (state == ST_SEARCH) begin
      state_next = ST_RESOLVE;
    end
  end

  always_comb begin
    count_next = count;
    if (fire && append) begin
      count_next = count + CNT_W'(1);
    end
    if (accept && item.record_start) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      code_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fire) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= key_wide[ID_WIDTH-1:0];
    end
    if (state == ST_SEARCH) begin
      hit_len <= 3'(5'd1 + index_bits(count));
    end
    if (fire) begin
      code <= result;
    end
  end

endmodule

### src/pid_checker.sv
// Port-level checks for the pooled index dictionary coder, bound to the top level.
// Depends on pid_pkg.
module pid_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input pid_pkg::item_beat_t item,
  input logic                code_valid,
  input logic                code_stall,
  input pid_pkg::code_beat_t code
);
  import pid_pkg::*;

  // a held result beat keeps its payload
  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(code))
    else $error("code beat changed while stalled");

  // the compare cycle after an accepted beat never takes another one
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken during compare cycle");

  a_ovf_not_new: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> !(code.overflow && code.is_new))
    else $error("overflow beat marked as new");

  // an empty code only comes from the first entry of a record
  a_empty_code: assert property (@(posedge clk) disable iff (rst)
    code_valid && (code.code_length == 3'd0) |->
      code.is_new && (code.slot == 6'd0) && (code.code_bits == 7'd0))
    else $error("zero-length code outside first entry");

endmodule

bind pooled_index_dictionary_coder pid_checker u_pid_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code       (code)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for pooled_index_dictionary_coder: corner beats first, then random records.
// Depends on pid_pkg and the RTL under src/; the scoreboard keeps its own dictionary copy.
module testbench;
  import pid_pkg::*;

  localparam int DEPTH        = DICT_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  class code_scoreboard;
    logic [15:0] dict [DEPTH];
    int          fill = 0;
    code_beat_t  expected_codes [$];
    int          errors = 0;
    int          checked = 0;
    int          hits = 0;
    int          appends = 0;
    int          overflows = 0;
    int          clears = 0;

    function code_beat_t predict_code(item_beat_t b);
      code_beat_t c;
      int         found;
      int         w;
      c     = '0;
      found = -1;
      w     = 0;
      if (b.record_start) begin
        fill = 0;
        clears++;
      end
      for (int i = 0; i < fill; i++) begin
        if (found < 0 && dict[i] == b.global_id) found = i;
      end
      if (found >= 0) begin
        // index width is ceil(log2(fill)), zero below two entries
        while ((1 << w) < fill) w++;
        c.code_bits   = 7'(found);
        c.code_length = 3'(1 + w);
        c.slot        = 6'(found);
        hits++;
      end else if (fill >= DEPTH) begin
        c.code_bits   = 7'd1;
        c.code_length = 3'd1;
        c.overflow    = 1'b1;
        overflows++;
      end else begin
        // no bit at all for the first entry of a record
        if (fill > 0) begin
          c.code_bits   = 7'd1;
          c.code_length = 3'd1;
        end
        dict[fill] = b.global_id;
        c.slot     = 6'(fill);
        c.is_new   = 1'b1;
        fill++;
        appends++;
      end
      return c;
    endfunction

    function void note_item(item_beat_t b);
      expected_codes.push_back(predict_code(b));
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_code(code_beat_t c);
      code_beat_t e;
      if (expected_codes.size() == 0) begin
        $error("code beat %h arrived with nothing expected", c);
        errors++;
      end else begin
        e = expected_codes.pop_front();
        checked++;
        check_field("code_bits", e.code_bits, c.code_bits);
        check_field("code_length", e.code_length, c.code_length);
        check_field("is_new", e.is_new, c.is_new);
        check_field("slot", e.slot, c.slot);
        check_field("overflow", e.overflow, c.overflow);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_beat_t item;
  logic       code_valid;
  logic       code_stall;
  code_beat_t code;

  code_scoreboard sb = new();
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  pooled_index_dictionary_coder dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    code_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // output first: a code beat always belongs to an earlier item beat
  always @(posedge clk) begin
    if (!rst) begin
      if (code_valid && !code_stall) sb.check_code(code);
      if (item_valid && !item_stall) sb.note_item(item);
    end
  end

  task automatic send_id(input logic [15:0] id, input logic start);
    item_beat_t b;
    b.global_id    = id;
    b.record_start = start;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item       <= b;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_id();
    case ($urandom_range(15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Long records fill the dictionary with distinct ids, then pick ids at random, which hit or overflow.
  task automatic run_record(input bit long_rec);
    logic [15:0] pool [$];
    int          n_pool;
    int          n_items;
    int          base;
    int          stride;
    logic [15:0] id;
    logic        start;
    pool.delete();
    if (long_rec) begin
      n_pool = $urandom_range(64, 76);
      base   = $urandom_range(0, 65535);
      stride = 2 * $urandom_range(0, 32767) + 1;
      for (int i = 0; i < n_pool; i++) pool.push_back(16'(base + i * stride));
      n_items = n_pool + $urandom_range(10, 40);
    end else begin
      n_pool = ($urandom_range(3) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      for (int i = 0; i < n_pool; i++) pool.push_back(rand_id());
      n_items = $urandom_range(1, 2 * n_pool + 4);
    end
    for (int i = 0; i < n_items; i++) begin
      start = (i == 0) && (long_rec || $urandom_range(7) != 0);
      if (long_rec && i < n_pool) begin
        id = pool[i];
      end else begin
        id = ($urandom_range(9) == 0) ? rand_id() : pool[$urandom_range(0, n_pool - 1)];
        // stray record start in the middle of a record
        if (i != 0 && $urandom_range(49) == 0) start = 1'b1;
      end
      send_id(id, start);
    end
  endtask

  initial begin
    int directed_n;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_id(16'h0000, 1'b1);  // first entry: empty code
    send_id(16'h0000, 1'b0);  // hit with one entry: zero index bits
    send_id(16'hFFFF, 1'b0);
    send_id(16'hFFFF, 1'b0);
    send_id(16'h0000, 1'b0);
    send_id(16'h8000, 1'b0);
    send_id(16'h7FFF, 1'b0);
    send_id(16'h5555, 1'b0);
    send_id(16'hAAAA, 1'b0);
    send_id(16'hAAAA, 1'b0);  // hit in a six-entry dictionary
    send_id(16'h1234, 1'b1);
    send_id(16'h1234, 1'b1);  // back-to-back record starts
    send_id(16'h4321, 1'b0);
    send_id(16'h4321, 1'b1);  // clear must win over the old match
    send_id(16'h1234, 1'b0);
    send_id(16'h4321, 1'b0);
    directed_n = items_sent;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      run_record(1'b1);
      while (items_sent < directed_n + (ph + 1) * ITEM_TARGET / 4)
        run_record($urandom_range(7) == 0);
    end
    item_valid <= 1'b0;

    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Coded %0d items in four idle/stall mixes, %0d record starts.",
             items_sent, sb.clears);
    $display("Checked %0d codes: %0d hits, %0d appends, %0d overflows.",
             sb.checked, sb.hits, sb.appends, sb.overflows);
    if (sb.errors == 0 && sb.expected_codes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
